[hw/rtl/cv3_pkg.sv]
// Shared constants and types for the 3x3 valid-window correlation block.
package cv3_pkg;

	localparam int DEF_MAX_SIZE   = 1024;
	localparam int DEF_PIXEL_BITS = 16;
	localparam int DEF_COEFF_BITS = 6;

	localparam int WIN            = 3;
	localparam int TAPS           = WIN * WIN;
	localparam int COEFF_PITCH    = 6;
	localparam int KERNEL_BITS    = TAPS * COEFF_PITCH;
	localparam int SIZE_BITS      = 11;
	localparam int SUM_BITS       = 25;
	localparam int CFG_DATA_BITS  = KERNEL_BITS;
	localparam int CFG_IDX_BITS   = 1;
	localparam int MIN_SIZE       = 3;

	localparam logic [KERNEL_BITS-1:0] KERNEL_RESET = 54'd281543712968705;
	localparam logic [SIZE_BITS-1:0]   SIZE_RESET   = 11'd5;

	localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIZE   = 1'd1;

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
	} ctl_t;

endpackage

[hw/rtl/cv3_if.sv]
// Valid/ready channel interfaces for the pixel stream and the window sum stream.
interface cv3_pix_if #(
	parameter int PIXEL_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [PIXEL_BITS-1:0] pixel;
	logic                         frame_start;

	modport source (output valid, output pixel, output frame_start, input ready);
	modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface cv3_sum_if;
	logic               valid;
	logic               ready;
	logic signed [24:0] window_sum;
	logic               frame_last;

	modport source (output valid, output window_sum, output frame_last, input ready);
	modport sink   (input valid, input window_sum, input frame_last, output ready);
endinterface

[hw/rtl/cv3_lbuf.sv]
// Raster counters, the two line memories and the first pipeline stage.
module cv3_lbuf
	import cv3_pkg::*;
#(
	parameter int MAX_SIZE   = DEF_MAX_SIZE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int CW         = $clog2(MAX_SIZE)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	cv3_pix_if.sink                      pixels,
	input  logic [CW-1:0]                n_m1,
	input  logic                         adv,
	output ctl_t                         ctl_s1,
	output logic signed [PIXEL_BITS-1:0] px_s1,
	output logic signed [PIXEL_BITS-1:0] up1_s1,
	output logic signed [PIXEL_BITS-1:0] up2_s1
);

	logic signed [PIXEL_BITS-1:0] mem_a [MAX_SIZE];
	logic signed [PIXEL_BITS-1:0] mem_b [MAX_SIZE];

	logic [CW-1:0] col_q;
	logic [CW-1:0] row_q;
	logic [CW-1:0] col_cur;
	logic [CW-1:0] row_cur;
	logic [CW-1:0] col_s1;
	logic          bwr_s1;
	logic          accept;

	assign pixels.ready = !ctl_s1.valid || adv;
	assign accept       = pixels.valid && pixels.ready;
	assign col_cur      = pixels.frame_start ? '0 : col_q;
	assign row_cur      = pixels.frame_start ? '0 : row_q;

	// The older line memory is filled in the cycle after each accept from the registered read of the newer
	// one, so a word that revisits the same column at once takes the pending value instead.
	always_ff @(posedge clk) begin
		if (bwr_s1) begin
			mem_b[col_s1] <= up1_s1;
		end
		if (accept) begin
			mem_a[col_cur] <= pixels.pixel;
			up1_s1         <= mem_a[col_cur];
			up2_s1         <= (bwr_s1 && (col_s1 == col_cur)) ? up1_s1 : mem_b[col_cur];
			px_s1          <= pixels.pixel;
			col_s1         <= col_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			ctl_s1 <= '0;
			bwr_s1 <= 1'b0;
		end else begin
			bwr_s1 <= accept;
			if (accept) begin
				ctl_s1.valid <= 1'b1;
				ctl_s1.emit  <= (row_cur >= CW'(WIN - 1)) && (col_cur >= CW'(WIN - 1));
				ctl_s1.last  <= (row_cur == n_m1) && (col_cur == n_m1);
				if (col_cur >= n_m1) begin
					col_q <= '0;
					row_q <= (row_cur >= n_m1) ? '0 : row_cur + CW'(1);
				end else begin
					col_q <= col_cur + CW'(1);
					row_q <= row_cur;
				end
			end else if (adv) begin
				ctl_s1.valid <= 1'b0;
			end
		end
	end

endmodule

[hw/rtl/cv3_mac.sv]
// Window shift register, nine products, their sum and the result register.
module cv3_mac
	import cv3_pkg::*;
#(
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int COEFF_BITS = DEF_COEFF_BITS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ctl_t                         ctl_s1,
	input  logic signed [PIXEL_BITS-1:0] px_s1,
	input  logic signed [PIXEL_BITS-1:0] up1_s1,
	input  logic signed [PIXEL_BITS-1:0] up2_s1,
	input  logic [KERNEL_BITS-1:0]       kernel,
	output logic                         adv,
	cv3_sum_if.source                    sums
);

	localparam int PROD_BITS = PIXEL_BITS + COEFF_BITS;
	localparam int ACC_BITS  = PROD_BITS + 4;

	logic signed [PIXEL_BITS-1:0] win_q   [TAPS];
	logic signed [PIXEL_BITS-1:0] win_nxt [TAPS];
	logic signed [COEFF_BITS-1:0] coef    [TAPS];
	logic signed [PROD_BITS-1:0]  prod    [TAPS];
	logic signed [ACC_BITS-1:0]   acc;
	logic signed [SUM_BITS-1:0]   sum_q;
	logic                         last_q;
	logic                         valid_q;
	logic                         step;

	assign adv  = !valid_q || sums.ready;
	assign step = ctl_s1.valid && adv;

	always_comb begin
		for (int r = 0; r < WIN; r++) begin
			for (int c = 0; c < WIN - 1; c++) begin
				win_nxt[r*WIN + c] = win_q[r*WIN + c + 1];
			end
		end
		win_nxt[WIN - 1]        = up2_s1;
		win_nxt[2*WIN - 1]      = up1_s1;
		win_nxt[TAPS - 1]       = px_s1;
	end

	always_comb begin
		acc = '0;
		for (int k = 0; k < TAPS; k++) begin
			coef[k] = COEFF_BITS'(kernel >> (COEFF_PITCH * k));
			prod[k] = win_nxt[k] * coef[k];
			acc     = acc + ACC_BITS'(prod[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAPS; k++) begin
				win_q[k] <= '0;
			end
			valid_q <= 1'b0;
		end else begin
			if (step) begin
				win_q   <= win_nxt;
				valid_q <= ctl_s1.emit;
			end else if (sums.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && ctl_s1.emit) begin
			sum_q  <= SUM_BITS'(acc);
			last_q <= ctl_s1.last;
		end
	end

	assign sums.valid      = valid_q;
	assign sums.window_sum = sum_q;
	assign sums.frame_last = last_q;

endmodule

[hw/rtl/conv3x3_valid_window_top.sv]
// Top level of the 3x3 valid-window correlation block with its register file.
//
// Usage: pixels of a square image enter on the pixels channel in raster order,
// one word per accepted handshake, with frame_start set on the first pixel of
// a frame. For every pixel at row >= 2 and column >= 2 one word leaves on the
// sums channel: the sum of the 3x3 window ending at that pixel multiplied by
// the kernel without flipping, with frame_last set on the last window.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// do so only while the block is idle (not enforced): index 0 holds nine packed
// signed coefficients, index 1 the image side length, clamped to 3..MAX_SIZE.
// Throughput is one pixel per cycle while the receiver does not stall. Each
// result passes through the registered line memory read, then through the
// products and the adder tree into the result register.
// Reset clears the counters, the window and both valid flags and restores
// the register defaults; line memory contents stay undefined until written.
// When the receiver stalls, the result register holds and the pipeline keeps
// taking pixels until its one internal stage is full.
module conv3x3_valid_window_top
	import cv3_pkg::*;
#(
	parameter int MAX_SIZE   = DEF_MAX_SIZE,
	parameter int PIXEL_BITS = DEF_PIXEL_BITS,
	parameter int COEFF_BITS = DEF_COEFF_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	cv3_pix_if.sink                  pixels,
	cv3_sum_if.source                sums
);

	localparam int CW = $clog2(MAX_SIZE);

	logic [KERNEL_BITS-1:0]       kernel_q;
	logic [SIZE_BITS-1:0]         size_q;
	logic [CW-1:0]                n_m1;
	logic                         adv;
	ctl_t                         ctl_s1;
	logic signed [PIXEL_BITS-1:0] px_s1;
	logic signed [PIXEL_BITS-1:0] up1_s1;
	logic signed [PIXEL_BITS-1:0] up2_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q <= KERNEL_RESET;
			size_q   <= SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KERNEL: kernel_q <= cfg_data;
				REG_SIZE:   size_q   <= cfg_data[SIZE_BITS-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (32'(size_q) < MIN_SIZE) begin
			n_m1 = CW'(MIN_SIZE - 1);
		end else if (32'(size_q) > MAX_SIZE) begin
			n_m1 = CW'(MAX_SIZE - 1);
		end else begin
			n_m1 = CW'(size_q - SIZE_BITS'(1));
		end
	end

	cv3_lbuf #(
		.MAX_SIZE   (MAX_SIZE),
		.PIXEL_BITS (PIXEL_BITS),
		.CW         (CW)
	) u_lbuf (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels),
		.n_m1   (n_m1),
		.adv    (adv),
		.ctl_s1 (ctl_s1),
		.px_s1  (px_s1),
		.up1_s1 (up1_s1),
		.up2_s1 (up2_s1)
	);

	cv3_mac #(
		.PIXEL_BITS (PIXEL_BITS),
		.COEFF_BITS (COEFF_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.px_s1  (px_s1),
		.up1_s1 (up1_s1),
		.up2_s1 (up2_s1),
		.kernel (kernel_q),
		.adv    (adv),
		.sums   (sums)
	);

endmodule

[hw/rtl/cv3_checker.sv]
// Port-level assertions for the correlation block and their binding.
module cv3_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_ready,
	input logic        sum_valid,
	input logic        sum_ready,
	input logic [24:0] sum_data,
	input logic        sum_last
);

	// A stalled result word keeps its contents.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		sum_valid && !sum_ready |=> sum_valid && $stable(sum_data) && $stable(sum_last))
		else $error("result word changed while stalled");

	// The input side only backs up when the result register is full and stalled.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> sum_valid && !sum_ready)
		else $error("input stalled without a stalled result");

	// A fresh result follows an accepted pixel through the first stage and the result register.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sum_valid) |-> $past(pix_valid && pix_ready, 2))
		else $error("result appeared without a pixel two cycles earlier");

	// The input register stage frees up whenever the output is drained.
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!sum_valid |-> pix_ready)
		else $error("input not ready while the result register is empty");

endmodule

bind conv3x3_valid_window_top cv3_checker u_cv3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pix_valid (pixels.valid),
	.pix_ready (pixels.ready),
	.sum_valid (sums.valid),
	.sum_ready (sums.ready),
	.sum_data  (sums.window_sum),
	.sum_last  (sums.frame_last)
);

[bench/tb.sv]
// Self-checking testbench for conv3x3_valid_window_top: predicts every window sum and checks it.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cv3_pkg::*;

	localparam int SIDE_MAX = DEF_MAX_SIZE;
	localparam int PIX_W    = DEF_PIXEL_BITS;

	typedef struct {
		logic signed [SUM_BITS-1:0] total;
		logic                       last;
	} window_result_t;

	class window_scoreboard;
		logic [KERNEL_BITS-1:0]   kernel;
		logic [SIZE_BITS-1:0]     side;
		logic signed [PIX_W-1:0]  row_above [SIDE_MAX];
		logic signed [PIX_W-1:0]  row_two_above [SIDE_MAX];
		logic signed [PIX_W-1:0]  win [TAPS];
		int unsigned              col;
		int unsigned              row;
		window_result_t           pending [$];
		int unsigned              errors;

		function new();
			kernel = KERNEL_RESET;
			side = SIZE_RESET;
			foreach (win[k]) win[k] = '0;
			col = 0;
			row = 0;
			errors = 0;
		endfunction

		static function int unsigned clamp_side(logic [SIZE_BITS-1:0] s);
			if (s < MIN_SIZE) return MIN_SIZE;
			if (s > SIDE_MAX) return SIDE_MAX;
			return s;
		endfunction

		function int unsigned side_len();
			return clamp_side(side);
		endfunction

		function bit at_origin();
			return col == 0 && row == 0;
		endfunction

		function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
			case (idx)
				REG_KERNEL: kernel = data[KERNEL_BITS-1:0];
				REG_SIZE: side = data[SIZE_BITS-1:0];
				default: ;
			endcase
		endfunction

		function void note_pixel(logic signed [PIX_W-1:0] px, logic fs);
			int unsigned n;
			longint acc;
			window_result_t res;
			n = clamp_side(side);
			if (fs) begin
				col = 0;
				row = 0;
			end
			for (int r = 0; r < WIN; r++) begin
				win[r*WIN] = win[r*WIN+1];
				win[r*WIN+1] = win[r*WIN+2];
			end
			win[2] = row_two_above[col];
			win[5] = row_above[col];
			win[8] = px;
			row_two_above[col] = row_above[col];
			row_above[col] = px;
			if (row >= 2 && col >= 2) begin
				acc = 0;
				for (int k = 0; k < TAPS; k++) begin
					acc += longint'($signed(kernel[COEFF_PITCH*k +: COEFF_PITCH])) * longint'(win[k]);
				end
				res.total = acc[SUM_BITS-1:0];
				res.last = (row == n - 1) && (col == n - 1);
				pending.push_back(res);
			end
			if (col >= n - 1) begin
				col = 0;
				row = (row >= n - 1) ? 0 : row + 1;
			end else begin
				col++;
			end
		endfunction

		function void check_sum(logic signed [SUM_BITS-1:0] total, logic last);
			window_result_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t ns: window_sum %0d frame_last %0b arrived with no word expected",
					$time, total, last);
				return;
			end
			want = pending.pop_front();
			if (total !== want.total) begin
				errors++;
				$display("%0t ns: window_sum expected %0d, got %0d", $time, want.total, total);
			end
			if (last !== want.last) begin
				errors++;
				$display("%0t ns: frame_last expected %0b, got %0b", $time, want.last, last);
			end
		endfunction
	endclass

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [CFG_IDX_BITS-1:0]   cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	bit                        steady;
	int unsigned               words_sent;
	window_scoreboard          sb = new();

	cv3_pix_if #(.PIXEL_BITS(PIX_W)) pix_ch ();
	cv3_sum_if sum_ch ();

	conv3x3_valid_window_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.pixels    (pix_ch),
		.sums      (sum_ch)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	always @(negedge clk) begin
		sum_ch.ready <= steady || ($urandom_range(0, 99) >= 25);
	end

	always @(posedge clk) begin
		if (arst_n && pix_ch.valid && pix_ch.ready) begin
			sb.note_pixel(pix_ch.pixel, pix_ch.frame_start);
		end
		if (arst_n && sum_ch.valid && sum_ch.ready) begin
			sb.check_sum(sum_ch.window_sum, sum_ch.frame_last);
		end
	end

	function automatic logic signed [PIX_W-1:0] pick_pixel();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'sh0000;
			3: return 16'shffff;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	function automatic logic [KERNEL_BITS-1:0] pick_kernel();
		logic [KERNEL_BITS-1:0] k;
		k = KERNEL_BITS'({$urandom, $urandom});
		case ($urandom_range(0, 7))
			0: k = {TAPS{6'b100000}};
			1: k = {TAPS{6'b011111}};
			2: k = KERNEL_RESET;
			default: ;
		endcase
		return k;
	endfunction

	function automatic logic [SIZE_BITS-1:0] pick_side();
		case ($urandom_range(0, 9))
			0: return SIZE_BITS'($urandom_range(0, 2));
			1: return SIZE_BITS'($urandom_range(11, 20));
			default: return SIZE_BITS'($urandom_range(MIN_SIZE, 10));
		endcase
	endfunction

	task automatic send_word(input logic signed [PIX_W-1:0] px, input logic fs);
		while (!steady && $urandom_range(0, 99) < 25) begin
			pix_ch.valid <= 1'b0;
			@(negedge clk);
		end
		pix_ch.valid <= 1'b1;
		pix_ch.pixel <= px;
		pix_ch.frame_start <= fs;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		@(negedge clk);
		words_sent++;
	endtask

	task automatic stream(input int unsigned count, input bit mark_first, input int unsigned mark_pct);
		for (int unsigned i = 0; i < count; i++) begin
			send_word(pick_pixel(), (i == 0 && mark_first) || ($urandom_range(0, 99) < mark_pct));
		end
	endtask

	task automatic drain();
		pix_ch.valid <= 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic configure(input logic [KERNEL_BITS-1:0] k, input logic [SIZE_BITS-1:0] s);
		logic [CFG_DATA_BITS-1:0] size_data;
		size_data = CFG_DATA_BITS'({$urandom, $urandom});
		if ($urandom_range(0, 1)) size_data = '0;
		size_data[SIZE_BITS-1:0] = s;
		cfg_we <= 1'b1;
		cfg_index <= REG_KERNEL;
		cfg_data <= k;
		@(negedge clk);
		cfg_index <= REG_SIZE;
		cfg_data <= size_data;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(REG_KERNEL, k);
		sb.write_reg(REG_SIZE, size_data);
	endtask

	initial begin
		logic signed [PIX_W-1:0] corners [4];
		logic [SIZE_BITS-1:0]    side_val;
		int unsigned             n;
		int unsigned             phase;
		bit                      mark;

		corners = '{16'sh0000, 16'shffff, 16'sh7fff, 16'sh8000};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel = '0;
		pix_ch.frame_start = 1'b0;
		sum_ch.ready = 1'b0;
		steady = 1'b0;
		words_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// The second frame carries no start mark and relies on the counter wrap.
		configure({TAPS{6'b100000}}, '0);
		for (int i = 0; i < 9; i++) send_word(16'sh8000, i == 0);
		for (int i = 0; i < 9; i++) send_word(16'sh7fff, 1'b0);
		drain();
		configure({TAPS{6'b011111}}, SIZE_BITS'(MIN_SIZE));
		for (int i = 0; i < 11; i++) send_word(corners[i % 4], i == 0 || i == 2);

		words_sent = 0;
		phase = 0;
		while (phase < 16 || words_sent < 1500) begin
			drain();
			steady = (phase >= 4 && phase < 9);
			if (phase == 6 || phase == 14) begin
				side_val = (phase == 6) ? SIZE_BITS'(SIDE_MAX)
					: SIZE_BITS'($urandom_range(SIDE_MAX + 1, (1 << SIZE_BITS) - 1));
				configure(pick_kernel(), side_val);
				stream((phase == 6) ? 2 * SIDE_MAX + 30 : 3 * SIDE_MAX + 6, 1'b1, 0);
			end else begin
				side_val = pick_side();
				n = window_scoreboard::clamp_side(side_val);
				mark = $urandom_range(0, 4) != 0;
				// A larger side mid-frame would read line store entries never written.
				if (n > sb.side_len() && !sb.at_origin()) mark = 1'b1;
				configure(pick_kernel(), side_val);
				case ($urandom_range(0, 19))
					0, 1, 2: begin
						stream($urandom_range(1, n * n - 1), mark, 0);
						stream(n * n, 1'b1, 0);
					end
					3, 4, 5: begin
						stream($urandom_range(1, 2 * n * n), mark, 8);
					end
					default: begin
						repeat ($urandom_range(1, 3)) begin
							stream(n * n, mark, 0);
							mark = $urandom_range(0, 3) != 0;
						end
					end
				endcase
			end
			phase++;
		end

		pix_ch.valid <= 1'b0;
		for (int w = 0; w < 4000 && sb.pending.size() != 0; w++) @(negedge clk);
		repeat (8) @(negedge clk);
		if (sb.pending.size() != 0) begin
			$display("%0t ns: %0d window sums expected but never delivered", $time,
				sb.pending.size());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
